/* hw/rtl/bhs_pkg.sv */
// Shared types, codes and stage counts of the bilinear heightmap sampler.
package bhs_pkg;

    localparam logic [1:0] OP_WR_HEIGHT = 2'd0;
    localparam logic [1:0] OP_WR_EDGE   = 2'd1;
    localparam logic [1:0] OP_SAMPLE    = 2'd2;
    localparam logic [1:0] OP_RESERVED  = 2'd3;

    localparam logic [1:0] CORNER_NW = 2'd0;
    localparam logic [1:0] CORNER_NE = 2'd1;
    localparam logic [1:0] CORNER_SE = 2'd2;
    localparam logic [1:0] CORNER_SW = 2'd3;

    localparam int FRONT_STAGES  = 3;
    localparam int TABLE_STAGES  = 1;
    localparam int INTERP_STAGES = 5;
    localparam int SQRT_STEPS    = 25;
    localparam int DIV_PREP      = 1;
    localparam int DIV_STEPS     = 16;
    localparam int OUT_STAGES    = 1;

    localparam logic [49:0] RAD_BIAS = 50'h1_0000_0000;

    typedef enum logic [1:0] {
        K_REJECT,
        K_WRITE,
        K_SAMPLE
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [1:0]        op;
        logic [1:0]        corner;
        logic signed [15:0] wval;
        logic [8:0]        u;
        logic [8:0]        v;
    } t_front;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         edge_byte;
        logic [8:0]         u;
        logic [8:0]         v;
        logic signed [15:0] nw;
        logic signed [15:0] ne;
        logic signed [15:0] se;
        logic signed [15:0] sw;
    } t_cell;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         edge_byte;
        logic [23:0]        h;
        logic signed [24:0] sx;
        logic signed [24:0] sy;
    } t_side;

endpackage

/* hw/rtl/bhs_front.sv */
// Front end: classify the word, clamp the point, split it into cell and fraction, form address.
module bhs_front import bhs_pkg::*; #(
    parameter int TOWNS       = 4,
    parameter int CELLS       = 64,
    parameter int CELL_PIXELS = 32,
    parameter int AW          = 14
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_opcode,
    input  logic [3:0]         i_map_number,
    input  logic [5:0]         i_write_cell_x,
    input  logic [5:0]         i_write_cell_y,
    input  logic [1:0]         i_corner_index,
    input  logic signed [15:0] i_write_value,
    input  logic signed [20:0] i_point_x,
    input  logic signed [20:0] i_point_y,
    output logic               o_valid,
    output t_front             o_front,
    output logic [AW-1:0]      o_addr
);

    localparam int EXTENT    = CELLS * CELL_PIXELS * 256;
    localparam int MAP_WORDS = CELLS * CELLS;
    localparam int QW        = $clog2(CELLS * 256 + 1);
    localparam logic [28:0] RECIP = 29'((2**28 + CELL_PIXELS - 1) / CELL_PIXELS);

    // stage 1
    logic r1_v;
    t_kind r1_kind;
    logic [1:0] r1_op, r1_corner;
    logic [3:0] r1_map;
    logic [5:0] r1_wx, r1_wy;
    logic signed [15:0] r1_wval;
    logic [19:0] r1_px, r1_py;
    t_kind n1_kind;

    // stage 2
    logic r2_v;
    t_kind r2_kind;
    logic [1:0] r2_op, r2_corner;
    logic [5:0] r2_wx, r2_wy;
    logic signed [15:0] r2_wval;
    logic [QW-1:0] r2_qx, r2_qy;
    logic [AW-1:0] r2_base;
    logic [48:0] prod_x, prod_y;

    // stage 3
    logic r3_v;
    t_front r3_front;
    logic [AW-1:0] r3_addr;
    logic [6:0] cqx, cqy;
    logic [5:0] cx, cy, selx, sely;

    function automatic logic [19:0] clamp_point(input logic signed [20:0] p);
        logic [19:0] res;
        if (p[20]) begin
            res = '0;
        end else if ({2'b00, p} > 23'(EXTENT)) begin
            res = 20'(EXTENT);
        end else begin
            res = p[19:0];
        end
        return res;
    endfunction

    always_comb begin
        if (i_map_number == 4'd0 || i_map_number > 4'(TOWNS) || i_opcode == OP_RESERVED) begin
            n1_kind = K_REJECT;
        end else if (i_opcode == OP_SAMPLE) begin
            n1_kind = K_SAMPLE;
        end else if ({1'b0, i_write_cell_x} >= 7'(CELLS)
                     || {1'b0, i_write_cell_y} >= 7'(CELLS)) begin
            n1_kind = K_REJECT;
        end else begin
            n1_kind = K_WRITE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_kind   <= n1_kind;
        r1_op     <= i_opcode;
        r1_corner <= i_corner_index;
        r1_map    <= i_map_number;
        r1_wx     <= i_write_cell_x;
        r1_wy     <= i_write_cell_y;
        r1_wval   <= i_write_value;
        r1_px     <= clamp_point(i_point_x);
        r1_py     <= clamp_point(i_point_y);
    end

    // divide by the cell width through a reciprocal; exact for all clamped points
    assign prod_x = 49'(r1_px) * 49'(RECIP);
    assign prod_y = 49'(r1_py) * 49'(RECIP);

    always_ff @(posedge i_clk) begin
        r2_kind   <= r1_kind;
        r2_op     <= r1_op;
        r2_corner <= r1_corner;
        r2_wx     <= r1_wx;
        r2_wy     <= r1_wy;
        r2_wval   <= r1_wval;
        r2_qx     <= prod_x[28 +: QW];
        r2_qy     <= prod_y[28 +: QW];
        r2_base   <= AW'((32'(r1_map) - 32'd1) * 32'(MAP_WORDS));
    end

    // the far edge lands in the last cell with fraction 1.0
    assign cqx  = 7'(r2_qx >> 8);
    assign cqy  = 7'(r2_qy >> 8);
    assign cx   = (cqx >= 7'(CELLS)) ? 6'(CELLS - 1) : cqx[5:0];
    assign cy   = (cqy >= 7'(CELLS)) ? 6'(CELLS - 1) : cqy[5:0];
    assign selx = (r2_kind == K_SAMPLE) ? cx : r2_wx;
    assign sely = (r2_kind == K_SAMPLE) ? cy : r2_wy;

    always_ff @(posedge i_clk) begin
        r3_front.kind   <= r2_kind;
        r3_front.op     <= r2_op;
        r3_front.corner <= r2_corner;
        r3_front.wval   <= r2_wval;
        r3_front.u      <= 9'(r2_qx - (QW'(cx) << 8));
        r3_front.v      <= 9'(r2_qy - (QW'(cy) << 8));
        r3_addr         <= r2_base + AW'(32'(sely) * 32'(CELLS) + 32'(selx));
    end

    assign o_valid = r3_v;
    assign o_front = r3_front;
    assign o_addr  = r3_addr;

endmodule

/* hw/rtl/bhs_table.sv */
// Corner height banks and hard-edge byte memory: at most one write per word, and every word reads its address.
module bhs_table import bhs_pkg::*; #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_front        i_front,
    input  logic [AW-1:0] i_addr,
    output logic          o_valid,
    output t_cell         o_cell
);

    logic signed [15:0] r_rd [4];
    logic [7:0] mem_edge [DEPTH];
    logic [7:0] r_edge;
    logic r_v;
    t_kind r_kind;
    logic [8:0] r_u, r_v_frac;
    logic wr_ok;

    assign wr_ok = i_valid && (i_front.kind == K_WRITE);

    for (genvar c = 0; c < 4; c++) begin : g_bank
        logic signed [15:0] mem_h [DEPTH];
        always_ff @(posedge i_clk) begin
            if (wr_ok && i_front.op == OP_WR_HEIGHT && i_front.corner == 2'(c)) begin
                mem_h[i_addr] <= i_front.wval;
            end
            r_rd[c] <= mem_h[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok && i_front.op == OP_WR_EDGE) begin
            mem_edge[i_addr] <= i_front.wval[7:0];
        end
        r_edge   <= mem_edge[i_addr];
        r_kind   <= i_front.kind;
        r_u      <= i_front.u;
        r_v_frac <= i_front.v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else begin
            r_v <= i_valid;
        end
    end

    assign o_valid          = r_v;
    assign o_cell.kind      = r_kind;
    assign o_cell.edge_byte = r_edge;
    assign o_cell.u         = r_u;
    assign o_cell.v         = r_v_frac;
    assign o_cell.nw        = r_rd[CORNER_NW];
    assign o_cell.ne        = r_rd[CORNER_NE];
    assign o_cell.se        = r_rd[CORNER_SE];
    assign o_cell.sw        = r_rd[CORNER_SW];

endmodule

/* hw/rtl/bhs_interp.sv */
// Bilinear height, slopes and squared slope length over five stages.
module bhs_interp import bhs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_cell       i_cell,
    output logic        o_valid,
    output t_side       o_side,
    output logic [49:0] o_rad
);

    logic [INTERP_STAGES-1:0] r_v;
    t_side r_side [INTERP_STAGES];

    logic signed [9:0] iu_s, u_s, r1_ius, r1_us, r1_ivs, r1_vs, r2_ivs, r2_vs;
    logic signed [25:0] r1_pnw, r1_pne, r1_pse, r1_psw;
    logic signed [16:0] r1_dxn, r1_dxs, r1_dyw, r1_dye;
    logic signed [26:0] r2_north, r2_south, r2_a, r2_b, r2_c, r2_d;
    logic signed [36:0] r3_hn, r3_hs;
    logic signed [24:0] r3_sx, r3_sy;
    logic signed [37:0] hsum;
    logic signed [49:0] r4_sqx, r4_sqy;
    logic [49:0] r5_rad;

    assign iu_s = $signed({1'b0, 9'(9'd256 - i_cell.u)});
    assign u_s  = $signed({1'b0, i_cell.u});
    assign hsum = 38'(r3_hn) + 38'(r3_hs) + 38'sd128;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[INTERP_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        // weights and corner differences
        r_side[0] <= '{kind: i_cell.kind, edge_byte: i_cell.edge_byte,
                       h: '0, sx: '0, sy: '0};
        r1_pnw <= i_cell.nw * iu_s;
        r1_pne <= i_cell.ne * u_s;
        r1_pse <= i_cell.se * u_s;
        r1_psw <= i_cell.sw * iu_s;
        r1_dxn <= 17'(i_cell.ne) - 17'(i_cell.nw);
        r1_dxs <= 17'(i_cell.se) - 17'(i_cell.sw);
        r1_dyw <= 17'(i_cell.sw) - 17'(i_cell.nw);
        r1_dye <= 17'(i_cell.se) - 17'(i_cell.ne);
        r1_ius <= iu_s;
        r1_us  <= u_s;
        r1_ivs <= $signed({1'b0, 9'(9'd256 - i_cell.v)});
        r1_vs  <= $signed({1'b0, i_cell.v});

        // edge rows and slope terms
        r_side[1] <= r_side[0];
        r2_north  <= 27'(r1_pnw) + 27'(r1_pne);
        r2_south  <= 27'(r1_psw) + 27'(r1_pse);
        r2_a      <= r1_dxn * r1_ivs;
        r2_b      <= r1_dxs * r1_vs;
        r2_c      <= r1_dyw * r1_ius;
        r2_d      <= r1_dye * r1_us;
        r2_ivs    <= r1_ivs;
        r2_vs     <= r1_vs;

        // blend rows, sum slopes
        r_side[2] <= r_side[1];
        r3_hn     <= r2_north * r2_ivs;
        r3_hs     <= r2_south * r2_vs;
        r3_sx     <= 25'(r2_a + r2_b);
        r3_sy     <= 25'(r2_c + r2_d);

        // round height half up to Q16.8, square slopes
        r_side[3] <= '{kind: r_side[2].kind, edge_byte: r_side[2].edge_byte,
                       h: hsum[31:8], sx: r3_sx, sy: r3_sy};
        r4_sqx    <= r3_sx * r3_sx;
        r4_sqy    <= r3_sy * r3_sy;

        r_side[4] <= r_side[3];
        r5_rad    <= $unsigned(r4_sqx) + $unsigned(r4_sqy) + RAD_BIAS;
    end

    assign o_valid = r_v[INTERP_STAGES-1];
    assign o_side  = r_side[INTERP_STAGES-1];
    assign o_rad   = r5_rad;

endmodule

/* hw/rtl/bhs_normal.sv */
// Normal vector: pipelined square root, one root bit per stage, then three shared-divisor dividers.
module bhs_normal import bhs_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_side       i_side,
    input  logic [49:0] i_rad,
    output logic        o_valid,
    output t_side       o_side,
    output logic [15:0] o_q_east,
    output logic [15:0] o_q_south,
    output logic [15:0] o_q_up
);

    logic        r_sq_v    [SQRT_STEPS];
    t_side       r_sq_side [SQRT_STEPS];
    logic [49:0] r_sq_rem  [SQRT_STEPS];
    logic [49:0] r_sq_root [SQRT_STEPS];

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sq
        localparam int K = SQRT_STEPS - 1 - i;
        logic v_in;
        t_side side_in;
        logic [49:0] rem_in, root_in, trial;
        if (i == 0) begin : g_first
            assign v_in    = i_valid;
            assign side_in = i_side;
            assign rem_in  = i_rad;
            assign root_in = '0;
        end else begin : g_next
            assign v_in    = r_sq_v[i-1];
            assign side_in = r_sq_side[i-1];
            assign rem_in  = r_sq_rem[i-1];
            assign root_in = r_sq_root[i-1];
        end
        assign trial = root_in + (50'(1) << (2 * K));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[i] <= 1'b0;
            end else begin
                r_sq_v[i] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_sq_side[i] <= side_in;
            if (rem_in >= trial) begin
                r_sq_rem[i]  <= rem_in - trial;
                r_sq_root[i] <= (root_in >> 1) + (50'(1) << (2 * K));
            end else begin
                r_sq_rem[i]  <= rem_in;
                r_sq_root[i] <= root_in >> 1;
            end
        end
    end

    // prepare rounded dividends: east, south, up
    logic [24:0] root, mag_e, mag_s;
    logic r_pv;
    t_side r_pside;
    logic [24:0] r_proot;
    logic [39:0] r_pdiv [3];

    assign root  = r_sq_root[SQRT_STEPS-1][24:0];
    assign mag_e = r_sq_side[SQRT_STEPS-1].sx[24] ? 25'(-r_sq_side[SQRT_STEPS-1].sx)
                                                  : 25'(r_sq_side[SQRT_STEPS-1].sx);
    assign mag_s = r_sq_side[SQRT_STEPS-1].sy[24] ? 25'(-r_sq_side[SQRT_STEPS-1].sy)
                                                  : 25'(r_sq_side[SQRT_STEPS-1].sy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= r_sq_v[SQRT_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_pside   <= r_sq_side[SQRT_STEPS-1];
        r_proot   <= root;
        r_pdiv[0] <= {mag_e, 15'b0} + 40'(root >> 1);
        r_pdiv[1] <= {mag_s, 15'b0} + 40'(root >> 1);
        r_pdiv[2] <= 40'h00_8000_0000 + 40'(root >> 1);
    end

    logic        r_dv_v    [DIV_STEPS];
    t_side       r_dv_side [DIV_STEPS];
    logic [24:0] r_dv_root [DIV_STEPS];
    logic [39:0] r_dv_rem  [DIV_STEPS][3];
    logic [15:0] r_dv_q    [DIV_STEPS][3];

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_dv
        localparam int B = DIV_STEPS - 1 - i;
        logic v_in;
        t_side side_in;
        logic [24:0] root_in;
        logic [39:0] rem_in [3];
        logic [15:0] q_in [3];
        logic [40:0] dsh;
        if (i == 0) begin : g_first
            assign v_in    = r_pv;
            assign side_in = r_pside;
            assign root_in = r_proot;
            for (genvar j = 0; j < 3; j++) begin : g_lane
                assign rem_in[j] = r_pdiv[j];
                assign q_in[j]   = '0;
            end
        end else begin : g_next
            assign v_in    = r_dv_v[i-1];
            assign side_in = r_dv_side[i-1];
            assign root_in = r_dv_root[i-1];
            for (genvar j = 0; j < 3; j++) begin : g_lane
                assign rem_in[j] = r_dv_rem[i-1][j];
                assign q_in[j]   = r_dv_q[i-1][j];
            end
        end
        assign dsh = 41'(root_in) << B;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[i] <= 1'b0;
            end else begin
                r_dv_v[i] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_dv_side[i] <= side_in;
            r_dv_root[i] <= root_in;
            for (int j = 0; j < 3; j++) begin
                if ({1'b0, rem_in[j]} >= dsh) begin
                    r_dv_rem[i][j] <= 40'({1'b0, rem_in[j]} - dsh);
                    r_dv_q[i][j]   <= q_in[j] | (16'(1) << B);
                end else begin
                    r_dv_rem[i][j] <= rem_in[j];
                    r_dv_q[i][j]   <= q_in[j];
                end
            end
        end
    end

    assign o_valid   = r_dv_v[DIV_STEPS-1];
    assign o_side    = r_dv_side[DIV_STEPS-1];
    assign o_q_east  = r_dv_q[DIV_STEPS-1][0];
    assign o_q_south = r_dv_q[DIV_STEPS-1][1];
    assign o_q_up    = r_dv_q[DIV_STEPS-1][2];

endmodule

/* hw/rtl/bilinear_heightmap_sampler.sv */
// Top level of the bilinear heightmap sampler: pipeline chain and result register.
//
// One word is taken in every clock cycle (start while busy is low) and its
// result appears on the o_ ports from the result register, marked by
// o_strobe for one cycle; the receiver cannot hold results off, so results
// must be taken when strobed. The pipeline runs through the front end (3 stages),
// the table read (1), the bilinear math (5), the 25-stage square root, a
// dividend stage, the 16-stage normal dividers and the result
// register. Every word gives one result: table writes return valid_res 1 with
// zeros, rejected words (bad map, bad opcode, write cell off the map) return
// valid_res 0 with zeros. busy is high only during reset; there is no
// clearing pass, and sampling a cell never written returns undefined fields.
// A write is seen by any sample that starts in a later cycle.
module bilinear_heightmap_sampler import bhs_pkg::*; #(
    parameter int TOWNS       = 4,
    parameter int CELLS       = 64,
    parameter int CELL_PIXELS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_opcode,
    input  logic [3:0]         i_map_number,
    input  logic [5:0]         i_write_cell_x,
    input  logic [5:0]         i_write_cell_y,
    input  logic [1:0]         i_corner_index,
    input  logic signed [15:0] i_write_value,
    input  logic signed [20:0] i_point_x,
    input  logic signed [20:0] i_point_y,
    output logic               o_strobe,
    output logic               o_valid_res,
    output logic signed [23:0] o_height,
    output logic signed [24:0] o_slope_east,
    output logic signed [24:0] o_slope_south,
    output logic signed [15:0] o_normal_east,
    output logic signed [15:0] o_normal_south,
    output logic [14:0]        o_normal_up,
    output logic [7:0]         o_edge_flags
);

    localparam int DEPTH   = TOWNS * CELLS * CELLS;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int LATENCY = FRONT_STAGES + TABLE_STAGES + INTERP_STAGES + SQRT_STEPS
                           + DIV_PREP + DIV_STEPS + OUT_STAGES;

    logic accept;
    logic r_busy;

    logic f_valid, t_valid, p_valid, n_valid;
    t_front f_word;
    logic [AW-1:0] f_addr;
    t_cell t_word;
    t_side p_side, n_side;
    logic [49:0] p_rad;
    logic [15:0] q_east, q_south, q_up;

    logic r_strobe, r_valid_res;
    logic signed [23:0] r_height;
    logic signed [24:0] r_slope_east, r_slope_south;
    logic signed [15:0] r_normal_east, r_normal_south;
    logic [14:0] r_normal_up;
    logic [7:0] r_edge_flags;

    logic n_valid_res;
    logic signed [23:0] n_height;
    logic signed [24:0] n_slope_east, n_slope_south;
    logic signed [15:0] n_normal_east, n_normal_south;
    logic [14:0] n_normal_up;
    logic [7:0] n_edge_flags;

    assign accept = start && !busy;

    // hold busy through reset, drop it afterward
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end
    assign busy = r_busy;

    bhs_front #(
        .TOWNS(TOWNS), .CELLS(CELLS), .CELL_PIXELS(CELL_PIXELS), .AW(AW)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(accept),
        .i_opcode(i_opcode), .i_map_number(i_map_number),
        .i_write_cell_x(i_write_cell_x), .i_write_cell_y(i_write_cell_y),
        .i_corner_index(i_corner_index), .i_write_value(i_write_value),
        .i_point_x(i_point_x), .i_point_y(i_point_y),
        .o_valid(f_valid), .o_front(f_word), .o_addr(f_addr)
    );

    bhs_table #(.DEPTH(DEPTH), .AW(AW)) u_table (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(f_valid), .i_front(f_word),
        .i_addr(f_addr), .o_valid(t_valid), .o_cell(t_word)
    );

    bhs_interp u_interp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(t_valid), .i_cell(t_word),
        .o_valid(p_valid), .o_side(p_side), .o_rad(p_rad)
    );

    bhs_normal u_normal (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(p_valid), .i_side(p_side),
        .i_rad(p_rad), .o_valid(n_valid), .o_side(n_side),
        .o_q_east(q_east), .o_q_south(q_south), .o_q_up(q_up)
    );

    // sign opposite to the slope, saturate to Q1.15
    function automatic logic signed [15:0] normal_part(input logic signed [24:0] s,
                                                       input logic [15:0] q);
        logic signed [16:0] neg;
        logic signed [15:0] res;
        neg = -$signed({1'b0, q});
        if (!s[24] && s != '0) begin
            res = neg[15:0];
        end else if (q > 16'd32767) begin
            res = 16'sd32767;
        end else begin
            res = $signed(q);
        end
        return res;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= n_valid;
        end
    end

    // zero every field unless the word was a sample
    always_comb begin
        n_valid_res    = 1'b0;
        n_height       = '0;
        n_slope_east   = '0;
        n_slope_south  = '0;
        n_normal_east  = '0;
        n_normal_south = '0;
        n_normal_up    = '0;
        n_edge_flags   = '0;
        case (n_side.kind)
            K_SAMPLE: begin
                n_valid_res    = 1'b1;
                n_height       = $signed(n_side.h);
                n_slope_east   = n_side.sx;
                n_slope_south  = n_side.sy;
                n_normal_east  = normal_part(n_side.sx, q_east);
                n_normal_south = normal_part(n_side.sy, q_south);
                n_normal_up    = (q_up > 16'd32767) ? 15'h7FFF : q_up[14:0];
                n_edge_flags   = n_side.edge_byte;
            end
            K_WRITE: begin
                n_valid_res = 1'b1;
            end
            default: begin
                n_valid_res = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_valid_res    <= n_valid_res;
        r_height       <= n_height;
        r_slope_east   <= n_slope_east;
        r_slope_south  <= n_slope_south;
        r_normal_east  <= n_normal_east;
        r_normal_south <= n_normal_south;
        r_normal_up    <= n_normal_up;
        r_edge_flags   <= n_edge_flags;
    end

    assign o_strobe       = r_strobe;
    assign o_valid_res    = r_valid_res;
    assign o_height       = r_height;
    assign o_slope_east   = r_slope_east;
    assign o_slope_south  = r_slope_south;
    assign o_normal_east  = r_normal_east;
    assign o_normal_south = r_normal_south;
    assign o_normal_up    = r_normal_up;
    assign o_edge_flags   = r_edge_flags;

    // every accepted word comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LATENCY o_strobe)
        else $error("accepted word not returned after fixed latency");

    // no result without an accepted word
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, LATENCY))
        else $error("result strobe without accepted word");

    // a rejected word carries zeros in height, slope east, normal up and edge flags
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_valid_res) |-> (o_height == '0 && o_normal_up == '0
                                        && o_edge_flags == '0 && o_slope_east == '0))
        else $error("rejected word carries nonzero fields");

    // a sample with a nonzero east component has a positive up component
    a_up_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_valid_res && o_normal_east != '0) |-> (o_normal_up != '0))
        else $error("tilted normal with zero up component");

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the bilinear heightmap sampler.
module testbench import bhs_pkg::*; ();

    localparam int MAPS       = 4;
    localparam int GRID       = 64;
    localparam int PIX        = 32;
    localparam int SPAN       = PIX * 256;        // one cell in Q8 pixels
    localparam int EXTENT     = GRID * SPAN;      // map edge in Q8 pixels
    localparam int RAND_WORDS = 1250;
    localparam int LATENCY    = 52;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        bit                 drain;   // hold off until every result is back
        logic [1:0]         op;
        logic [3:0]         map;
        logic [5:0]         wx;
        logic [5:0]         wy;
        logic [1:0]         corner;
        logic signed [15:0] wval;
        logic signed [20:0] px;
        logic signed [20:0] py;
    } t_word;

    typedef struct {
        logic               valid;
        logic signed [23:0] height;
        logic signed [24:0] slope_e;
        logic signed [24:0] slope_s;
        logic signed [15:0] norm_e;
        logic signed [15:0] norm_s;
        logic [14:0]        norm_up;
        logic [7:0]         flags;
    } t_sample;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic [1:0] i_opcode = '0;
    logic [3:0] i_map_number = '0;
    logic [5:0] i_write_cell_x = '0;
    logic [5:0] i_write_cell_y = '0;
    logic [1:0] i_corner_index = '0;
    logic signed [15:0] i_write_value = '0;
    logic signed [20:0] i_point_x = '0;
    logic signed [20:0] i_point_y = '0;
    logic o_strobe;
    logic o_valid_res;
    logic signed [23:0] o_height;
    logic signed [24:0] o_slope_east;
    logic signed [24:0] o_slope_south;
    logic signed [15:0] o_normal_east;
    logic signed [15:0] o_normal_south;
    logic [14:0] o_normal_up;
    logic [7:0] o_edge_flags;

    bilinear_heightmap_sampler i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_opcode(i_opcode), .i_map_number(i_map_number),
        .i_write_cell_x(i_write_cell_x), .i_write_cell_y(i_write_cell_y),
        .i_corner_index(i_corner_index), .i_write_value(i_write_value),
        .i_point_x(i_point_x), .i_point_y(i_point_y),
        .o_strobe(o_strobe), .o_valid_res(o_valid_res), .o_height(o_height),
        .o_slope_east(o_slope_east), .o_slope_south(o_slope_south),
        .o_normal_east(o_normal_east), .o_normal_south(o_normal_south),
        .o_normal_up(o_normal_up), .o_edge_flags(o_edge_flags)
    );

    always #4 i_clk = ~i_clk;

    // Predictor tables, updated as words are accepted.
    logic signed [15:0] height_tab [0:MAPS*GRID*GRID*4-1];
    logic [7:0]         flag_tab   [0:MAPS*GRID*GRID-1];
    // Generator shadow: which entries have writes queued so far.
    bit [3:0] corner_seen [0:MAPS*GRID*GRID-1];
    bit       flag_seen   [0:MAPS*GRID*GRID-1];

    t_word   pending_words[$];
    t_sample due_samples[$];
    int errors = 0;
    int n_samples = 0, n_writes = 0, n_rejects = 0;
    int cycles = 0;
    bit taken = 0;
    bit holding = 0;
    int burst_left = 0, gap_left = 0;

    function automatic int slot_of(int map, int x, int y);
        return ((map - 1) * GRID + y) * GRID + x;
    endfunction

    // Clamp a Q8 pixel coordinate and split it into cell and Q8 fraction.
    function automatic void split_axis(input longint p, output int cell_idx,
                                       output longint frac);
        longint c;
        if (p < 0) p = 0;
        if (p > EXTENT) p = EXTENT;
        c = p / SPAN;
        if (c >= GRID) c = GRID - 1;
        frac = (p - c * SPAN) / PIX;
        if (frac > 256) frac = 256;
        cell_idx = int'(c);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic longint unit_part(longint s, longint unsigned r);
        longint unsigned mag;
        longint q;
        mag = (s < 0) ? -s : s;
        q = longint'((mag * 32768 + r / 2) / r);
        q = (s > 0) ? -q : q;
        if (q < -32768) q = -32768;
        if (q > 32767) q = 32767;
        return q;
    endfunction

    // Work out the result of one accepted word and apply its table write.
    function automatic t_sample sample_result(t_word w);
        t_sample e;
        int cx, cy, slot;
        longint u, v, nw, ne, se, sw, north, south, h, sx, sy, up;
        longint unsigned r;
        e = '{default: '0};
        if (w.map < 1 || w.map > MAPS || w.op == OP_RESERVED) return e;
        if (w.op == OP_WR_HEIGHT || w.op == OP_WR_EDGE) begin
            slot = slot_of(int'(w.map), int'(w.wx), int'(w.wy));
            if (w.op == OP_WR_HEIGHT) height_tab[slot*4 + int'(w.corner)] = w.wval;
            else flag_tab[slot] = w.wval[7:0];
            e.valid = 1'b1;
            return e;
        end
        split_axis(longint'(w.px), cx, u);
        split_axis(longint'(w.py), cy, v);
        slot = slot_of(int'(w.map), cx, cy);
        nw = longint'(height_tab[slot*4 + int'(CORNER_NW)]);
        ne = longint'(height_tab[slot*4 + int'(CORNER_NE)]);
        se = longint'(height_tab[slot*4 + int'(CORNER_SE)]);
        sw = longint'(height_tab[slot*4 + int'(CORNER_SW)]);
        north = nw * (256 - u) + ne * u;
        south = sw * (256 - u) + se * u;
        h = (north * (256 - v) + south * v + 128) >>> 8;   // round half up
        sx = (ne - nw) * (256 - v) + (se - sw) * v;
        sy = (sw - nw) * (256 - u) + (se - ne) * u;
        r = int_sqrt(longint'(sx * sx) + longint'(sy * sy) + (64'd1 << 32));
        up = longint'(((64'd1 << 31) + r / 2) / r);
        if (up > 32767) up = 32767;
        e.valid   = 1'b1;
        e.height  = h[23:0];
        e.slope_e = sx[24:0];
        e.slope_s = sy[24:0];
        e.norm_e  = 16'(unit_part(sx, r));
        e.norm_s  = 16'(unit_part(sy, r));
        e.norm_up = up[14:0];
        e.flags   = flag_tab[slot];
        return e;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %s: got %0d, want %0d (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    // Queue helpers used by the stimulus thread.
    function automatic t_word blank_word();
        t_word w;
        w = '{default: '0};
        w.wval = 16'($urandom);
        w.px = 21'($urandom);
        w.py = 21'($urandom);
        return w;
    endfunction

    function automatic void push_height(int map, int x, int y, logic [1:0] c, int val);
        t_word w;
        w = blank_word();
        w.op = OP_WR_HEIGHT; w.map = 4'(map); w.wx = 6'(x); w.wy = 6'(y);
        w.corner = c; w.wval = 16'(val);
        pending_words.push_back(w);
        if (map >= 1 && map <= MAPS) corner_seen[slot_of(map, x, y)][c] = 1;
    endfunction

    function automatic void push_flags(int map, int x, int y, int val);
        t_word w;
        w = blank_word();
        w.op = OP_WR_EDGE; w.map = 4'(map); w.wx = 6'(x); w.wy = 6'(y);
        w.wval = 16'(val);
        w.corner = 2'($urandom);
        pending_words.push_back(w);
        if (map >= 1 && map <= MAPS) flag_seen[slot_of(map, x, y)] = 1;
    endfunction

    function automatic void fill_cell(int map, int x, int y, int a, int b, int c, int d, int f);
        push_height(map, x, y, CORNER_NW, a);
        push_height(map, x, y, CORNER_NE, b);
        push_height(map, x, y, CORNER_SE, c);
        push_height(map, x, y, CORNER_SW, d);
        push_flags(map, x, y, f);
    endfunction

    // Queue a sample; load the cell it lands on first if it is not complete.
    function automatic void push_sample(int map, int px, int py);
        t_word w;
        int cx, cy, slot;
        longint fu;
        w = blank_word();
        w.op = OP_SAMPLE; w.map = 4'(map); w.px = 21'(px); w.py = 21'(py);
        w.wx = 6'($urandom); w.wy = 6'($urandom); w.corner = 2'($urandom);
        if (map >= 1 && map <= MAPS) begin
            split_axis(longint'(w.px), cx, fu);
            split_axis(longint'(w.py), cy, fu);
            slot = slot_of(map, cx, cy);
            if (corner_seen[slot] != 4'hF || !flag_seen[slot])
                fill_cell(map, cx, cy, $urandom, $urandom, $urandom, $urandom, $urandom);
        end
        pending_words.push_back(w);
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(0, 9))
            0: return $urandom;                               // any 21-bit value
            1: return -$urandom_range(1, 4096);               // just off the near edge
            2: return EXTENT + $urandom_range(0, 4096);       // at or past the far edge
            3: return $urandom_range(0, GRID - 1) * SPAN;     // exactly on a cell line
            default: return $urandom_range(0, EXTENT);
        endcase
    endfunction

    initial begin
        t_word w;
        int shared_y;
        bit half_done;
        // Directed: extreme and zero corners on the four clamp cells of map 1.
        fill_cell(1, 0, 0, 32767, -32768, 32767, -32768, 'hABFF);
        fill_cell(1, 63, 63, -32768, -32768, -32768, -32768, 'h5500);
        fill_cell(1, 0, 63, 0, 0, 0, 0, 'h0081);
        fill_cell(1, 63, 0, -32768, 32767, 32767, -32768, 'hFF7E);
        push_sample(1, -1048576, -1048576);
        push_sample(1, 1048575, 1048575);
        push_sample(1, EXTENT, EXTENT);             // far edge: u = v = 1.0
        push_sample(1, 0, EXTENT - 1);
        push_sample(1, EXTENT - 1, 16);
        push_sample(1, 128, 200);
        // Rejected words: bad map numbers, unused opcode.
        push_height(0, 5, 5, CORNER_SE, 1234);
        push_flags(5, 5, 5, 'h00FF);
        push_sample(15, 100, 100);
        w = blank_word();
        w.op = OP_RESERVED; w.map = 4'd2; w.wx = 6'd63; w.wy = 6'd63; w.corner = CORNER_SW;
        pending_words.push_back(w);
        // Top map, zero-height flat cell.
        fill_cell(MAPS, 31, 17, 0, 0, 0, 0, 'h3C00);
        push_sample(MAPS, 31 * SPAN + 4000, 17 * SPAN + 8191);

        // Random part: mostly well-formed samples, the rest writes and noise.
        half_done = 0;
        while (pending_words.size() < RAND_WORDS) begin
            if (!half_done && pending_words.size() >= RAND_WORDS / 2) begin
                w = '{default: '0};
                w.drain = 1;
                pending_words.push_back(w);
                half_done = 1;
            end
            case ($urandom_range(0, 19))
                0, 1: begin
                    w = blank_word();
                    w.op = 2'($urandom);
                    w.map = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(MAPS + 1, 15));
                    w.wx = 6'($urandom); w.wy = 6'($urandom); w.corner = 2'($urandom);
                    if (w.op == OP_RESERVED) w.map = 4'($urandom);
                    pending_words.push_back(w);
                end
                2, 3, 4, 5: begin
                    if ($urandom_range(0, 3) == 0)
                        push_flags($urandom_range(1, MAPS), $urandom_range(0, GRID - 1),
                                   $urandom_range(0, GRID - 1), $urandom);
                    else
                        push_height($urandom_range(1, MAPS), $urandom_range(0, GRID - 1),
                                    $urandom_range(0, GRID - 1), 2'($urandom_range(0, 3)),
                                    $urandom);
                end
                6: begin
                    // short run along one row to reuse loaded cells
                    shared_y = rand_coord();
                    repeat (4) push_sample($urandom_range(1, MAPS), rand_coord(), shared_y);
                end
                default: push_sample($urandom_range(1, MAPS), rand_coord(), rand_coord());
            endcase
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_words.size() == 0 && !start && due_samples.size() == 0);
        repeat (LATENCY + 8) @(posedge i_clk);
        if (due_samples.size() != 0)
            report("leftover results", longint'(due_samples.size()), longint'(0));
        $display("checked %0d samples, %0d table writes, %0d rejected words",
                 n_samples, n_writes, n_rejects);
        $display("with clamped and far-edge points, extreme heights and bursty input");
        if (errors == 0) begin
            $display("bilinear_heightmap_sampler regression: pass");
        end else begin
            $display("bilinear_heightmap_sampler regression: fail");
        end
        $finish;
    end

    // Driver: change inputs on the falling edge; bursts with random gaps.
    always @(negedge i_clk) begin
        t_word w;
        bit next_start;
        next_start = start && !taken;
        if (i_rst_n && !next_start) begin
            if (holding) begin
                if (due_samples.size() == 0) holding = 0;
            end else if (gap_left > 0) begin
                gap_left--;
            end else if (pending_words.size() > 0) begin
                w = pending_words.pop_front();
                if (w.drain) begin
                    holding = 1;
                end else begin
                    i_opcode <= w.op;
                    i_map_number <= w.map;
                    i_write_cell_x <= w.wx;
                    i_write_cell_y <= w.wy;
                    i_corner_index <= w.corner;
                    i_write_value <= w.wval;
                    i_point_x <= w.px;
                    i_point_y <= w.py;
                    next_start = 1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(0, 12);
                        gap_left = $urandom_range(0, 6);
                    end
                end
            end
        end
        start <= next_start;
    end

    // Acceptance and result check on the rising edge.
    always @(posedge i_clk) begin
        t_word w;
        t_sample e;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("bilinear_heightmap_sampler regression: fail");
            $finish;
        end else begin
            taken = start && !busy && i_rst_n;
            if (taken) begin
                w = '{default: '0};
                w.op = i_opcode; w.map = i_map_number; w.wx = i_write_cell_x;
                w.wy = i_write_cell_y; w.corner = i_corner_index; w.wval = i_write_value;
                w.px = i_point_x; w.py = i_point_y;
                e = sample_result(w);
                due_samples.push_back(e);
                if (!e.valid) n_rejects++;
                else if (w.op == OP_SAMPLE) n_samples++;
                else n_writes++;
            end
            if (i_rst_n && o_strobe) begin
                if (due_samples.size() == 0) begin
                    report("unexpected result", longint'(1), longint'(0));
                end else begin
                    e = due_samples.pop_front();
                    if (o_valid_res !== e.valid)
                        report("valid_res", longint'(o_valid_res), longint'(e.valid));
                    if (o_height !== e.height)
                        report("height", longint'(o_height), longint'(e.height));
                    if (o_slope_east !== e.slope_e)
                        report("slope_east", longint'(o_slope_east), longint'(e.slope_e));
                    if (o_slope_south !== e.slope_s)
                        report("slope_south", longint'(o_slope_south), longint'(e.slope_s));
                    if (o_normal_east !== e.norm_e)
                        report("normal_east", longint'(o_normal_east), longint'(e.norm_e));
                    if (o_normal_south !== e.norm_s)
                        report("normal_south", longint'(o_normal_south), longint'(e.norm_s));
                    if (o_normal_up !== e.norm_up)
                        report("normal_up", longint'(o_normal_up), longint'(e.norm_up));
                    if (o_edge_flags !== e.flags)
                        report("edge_flags", longint'(o_edge_flags), longint'(e.flags));
                end
            end
        end
    end

endmodule

/* sim.f */
hw/rtl/bhs_pkg.sv
hw/rtl/bhs_front.sv
hw/rtl/bhs_table.sv
hw/rtl/bhs_interp.sv
hw/rtl/bhs_normal.sv
hw/rtl/bilinear_heightmap_sampler.sv
tb/testbench.sv
